>>> sv/sxi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sxi_pkg
// Shared types and constants of the spectrum to XYZ integrator.
// ----------------------------------------------------------------------------
package sxi_pkg;

	localparam int MAX_BINS = 512;
	localparam int BIN_W    = 9;
	localparam int SAMPLE_W = 16;
	localparam int WEIGHT_W = 16;
	localparam int OUT_W    = 17;
	localparam int ACC_W    = 42;
	localparam int PROD_W   = SAMPLE_W + WEIGHT_W;
	localparam int HALF_W   = ACC_W / 2;
	localparam int RECIP_W  = 18;
	localparam int PP_W     = HALF_W + RECIP_W;
	localparam int SUM_W    = ACC_W + RECIP_W;
	localparam int OUT_SHIFT = 38;
	localparam int SCALED_W = SUM_W - OUT_SHIFT;

	// Reciprocal of the Y integral in unsigned Q0.24.
	localparam logic [RECIP_W-1:0] RECIP_Y = 18'd157006;
	localparam logic [OUT_W-1:0]   OUT_MAX = {OUT_W{1'b1}};

	// Depth of the queue between the front and the back end.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_ACC  = 1'b1
	} op_t;

	// One multiply-accumulate job handed from the front to the back end.
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [WEIGHT_W-1:0] wx;
		logic [WEIGHT_W-1:0] wy;
		logic [WEIGHT_W-1:0] wz;
		logic                add;
		logic                last;
	} work_t;

	typedef struct packed {
		logic [OUT_W-1:0] x;
		logic [OUT_W-1:0] y;
		logic [OUT_W-1:0] z;
	} xyz_t;

endpackage
`default_nettype wire

>>> sv/sxi_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sxi_front
// Accepts input items, loads the weight table and looks up the weights of
// each sample, then hands the job to the work queue.
// ----------------------------------------------------------------------------
module sxi_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic                          op,
	input  wire logic [sxi_pkg::BIN_W-1:0]     bin_index,
	input  wire logic [sxi_pkg::SAMPLE_W-1:0]  sample_value,
	input  wire logic [sxi_pkg::WEIGHT_W-1:0]  weight_x,
	input  wire logic [sxi_pkg::WEIGHT_W-1:0]  weight_y,
	input  wire logic [sxi_pkg::WEIGHT_W-1:0]  weight_z,
	input  wire logic                          last_bin,
	output logic                               q_push,
	output sxi_pkg::work_t                     q_din,
	input  wire logic                          q_full
);
	import sxi_pkg::*;

	localparam int ROW_W = 3 * WEIGHT_W;

	logic [ROW_W-1:0]    wtab_q [MAX_BINS];
	logic [ROW_W-1:0]    rd_q;
	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                add_s1;
	logic                last_s1;
	logic                accept;
	logic                in_range;
	op_t                 op_in;

	assign op_in    = op_t'(op);
	assign full     = valid_s1 && q_full;
	assign accept   = push && !full;
	assign in_range = {1'b0, bin_index} < (BIN_W + 1)'(MAX_BINS);
	assign q_push   = valid_s1 && !q_full;

	always_comb begin
		q_din.sample = sample_s1;
		q_din.wx     = rd_q[3*WEIGHT_W-1:2*WEIGHT_W];
		q_din.wy     = rd_q[2*WEIGHT_W-1:WEIGHT_W];
		q_din.wz     = rd_q[WEIGHT_W-1:0];
		q_din.add    = add_s1;
		q_din.last   = last_s1;
	end

	// Weight table: written by loads, read by samples, one port each cycle.
	always_ff @(posedge clk) begin
		if (accept && op_in == OP_LOAD && in_range) begin
			wtab_q[bin_index] <= {weight_x, weight_y, weight_z};
		end
		if (accept && op_in == OP_ACC) begin
			rd_q <= wtab_q[bin_index];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && op_in == OP_ACC) begin
			sample_s1 <= sample_value;
			add_s1    <= in_range;
			last_s1   <= last_bin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && op_in == OP_ACC) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule
`default_nettype wire

>>> sv/sxi_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sxi_queue
// Short first-in first-out queue of jobs between the front and the back end.
// ----------------------------------------------------------------------------
module sxi_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire sxi_pkg::work_t din,
	output logic                full,
	input  wire logic           pop,
	output sxi_pkg::work_t      dout,
	output logic                empty
);
	import sxi_pkg::*;

	work_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     cnt_q;
	logic                do_push;
	logic                do_pop;

	assign full    = cnt_q == (QPTR_W + 1)'(QDEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (QPTR_W + 1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/sxi_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sxi_back
// Multiply-accumulate of the three channels, normalization by the Y
// reciprocal, and a two-entry result buffer.
// ----------------------------------------------------------------------------
module sxi_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire sxi_pkg::work_t q_dout,
	input  wire logic           q_empty,
	output logic                q_pop,
	output logic                empty,
	input  wire logic           pop,
	output sxi_pkg::xyz_t       res
);
	import sxi_pkg::*;

	logic                adv;
	logic                v_s1;
	logic                add_s1;
	logic                last_s1;
	logic [PROD_W-1:0]   px_s1;
	logic [PROD_W-1:0]   py_s1;
	logic [PROD_W-1:0]   pz_s1;
	logic [ACC_W-1:0]    accx_q;
	logic [ACC_W-1:0]    accy_q;
	logic [ACC_W-1:0]    accz_q;
	logic [ACC_W-1:0]    nx_acc;
	logic [ACC_W-1:0]    ny_acc;
	logic [ACC_W-1:0]    nz_acc;
	logic                v_s2;
	logic [ACC_W-1:0]    sx_s2;
	logic [ACC_W-1:0]    sy_s2;
	logic [ACC_W-1:0]    sz_s2;
	logic                v_s3;
	logic [PP_W-1:0]     xlo_s3;
	logic [PP_W-1:0]     xhi_s3;
	logic [PP_W-1:0]     ylo_s3;
	logic [PP_W-1:0]     yhi_s3;
	logic [PP_W-1:0]     zlo_s3;
	logic [PP_W-1:0]     zhi_s3;
	xyz_t                res_new;
	xyz_t                res_q [2];
	logic                wr_q;
	logic                rd_q;
	logic [1:0]          cnt_q;
	logic                out_full;
	logic                enq;

	// Combines the two partial products, drops the fraction and saturates.
	function automatic logic [OUT_W-1:0] finish(input logic [PP_W-1:0] lo,
	                                            input logic [PP_W-1:0] hi);
		logic [SUM_W-1:0]    sum;
		logic [SCALED_W-1:0] v;
		sum = {hi, {HALF_W{1'b0}}} + SUM_W'(lo);
		v   = sum[SUM_W-1:OUT_SHIFT];
		return (|v[SCALED_W-1:OUT_W]) ? OUT_MAX : v[OUT_W-1:0];
	endfunction

	assign out_full = cnt_q == 2'd2;
	assign empty    = cnt_q == 2'd0;
	assign adv      = !(v_s3 && out_full);
	assign enq      = v_s3 && !out_full;
	assign q_pop    = adv && !q_empty;
	assign res      = res_q[rd_q];

	always_comb begin
		nx_acc = accx_q + (add_s1 ? ACC_W'(px_s1) : '0);
		ny_acc = accy_q + (add_s1 ? ACC_W'(py_s1) : '0);
		nz_acc = accz_q + (add_s1 ? ACC_W'(pz_s1) : '0);
		res_new.x = finish(xlo_s3, xhi_s3);
		res_new.y = finish(ylo_s3, yhi_s3);
		res_new.z = finish(zlo_s3, zhi_s3);
	end

	// Payload stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (q_pop) begin
				px_s1   <= PROD_W'(q_dout.sample) * PROD_W'(q_dout.wx);
				py_s1   <= PROD_W'(q_dout.sample) * PROD_W'(q_dout.wy);
				pz_s1   <= PROD_W'(q_dout.sample) * PROD_W'(q_dout.wz);
				add_s1  <= q_dout.add;
				last_s1 <= q_dout.last;
			end
			if (v_s1 && last_s1) begin
				sx_s2 <= nx_acc;
				sy_s2 <= ny_acc;
				sz_s2 <= nz_acc;
			end
			// The 42-bit sum times the reciprocal is split into two halves.
			if (v_s2) begin
				xlo_s3 <= PP_W'(sx_s2[HALF_W-1:0]) * PP_W'(RECIP_Y);
				xhi_s3 <= PP_W'(sx_s2[ACC_W-1:HALF_W]) * PP_W'(RECIP_Y);
				ylo_s3 <= PP_W'(sy_s2[HALF_W-1:0]) * PP_W'(RECIP_Y);
				yhi_s3 <= PP_W'(sy_s2[ACC_W-1:HALF_W]) * PP_W'(RECIP_Y);
				zlo_s3 <= PP_W'(sz_s2[HALF_W-1:0]) * PP_W'(RECIP_Y);
				zhi_s3 <= PP_W'(sz_s2[ACC_W-1:HALF_W]) * PP_W'(RECIP_Y);
			end
		end
		if (enq) begin
			res_q[wr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			accx_q <= '0;
			accy_q <= '0;
			accz_q <= '0;
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (adv) begin
				v_s1 <= q_pop;
				v_s2 <= v_s1 && last_s1;
				v_s3 <= v_s2;
				if (v_s1) begin
					if (last_s1) begin
						accx_q <= '0;
						accy_q <= '0;
						accz_q <= '0;
					end else begin
						accx_q <= nx_acc;
						accy_q <= ny_acc;
						accz_q <= nz_acc;
					end
				end
			end
			if (enq) begin
				wr_q <= !wr_q;
			end
			if (pop && !empty) begin
				rd_q <= !rd_q;
			end
			if (enq && !(pop && !empty)) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!enq && pop && !empty) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/spectrum_to_xyz_integrator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spectrum_to_xyz_integrator_top
// Integrates a spectrum against the CIE 1931 matching weights to give XYZ.
//
// Both sides look like a queue. An item is taken when push is high and full
// is low. A load item (op low) writes the three weights of its bin; a sample
// item (op high) adds sample times weight to the three sums. A sample marked
// last_bin produces one result, the three sums scaled by the Y reciprocal,
// and the sums clear for the next spectrum.
// One item is taken per cycle while full is low. After the edge that takes
// its last sample, a result passes the table read, the job queue, product,
// sum and the split reciprocal multiply to the result buffer, where it stays
// while empty is low until pop takes it.
// When the receiver stops popping, the result buffer fills, the back end
// holds, the four-entry job queue fills and full rises.
// Reset clears the sums and all queues; the weight table is not cleared, and
// each bin must be loaded before a sample reads it.
// ----------------------------------------------------------------------------
module spectrum_to_xyz_integrator_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic                          op,
	input  wire logic [sxi_pkg::BIN_W-1:0]     bin_index,
	input  wire logic [sxi_pkg::SAMPLE_W-1:0]  sample_value,
	input  wire logic [sxi_pkg::WEIGHT_W-1:0]  weight_x,
	input  wire logic [sxi_pkg::WEIGHT_W-1:0]  weight_y,
	input  wire logic [sxi_pkg::WEIGHT_W-1:0]  weight_z,
	input  wire logic                          last_bin,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [sxi_pkg::OUT_W-1:0]          x_out,
	output logic [sxi_pkg::OUT_W-1:0]          y_out,
	output logic [sxi_pkg::OUT_W-1:0]          z_out
);
	import sxi_pkg::*;

	logic  q_push;
	logic  q_full;
	logic  q_pop;
	logic  q_empty;
	work_t q_din;
	work_t q_dout;
	xyz_t  res;

	sxi_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.op           (op),
		.bin_index    (bin_index),
		.sample_value (sample_value),
		.weight_x     (weight_x),
		.weight_y     (weight_y),
		.weight_z     (weight_z),
		.last_bin     (last_bin),
		.q_push       (q_push),
		.q_din        (q_din),
		.q_full       (q_full)
	);

	sxi_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	sxi_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_dout  (q_dout),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.res     (res)
	);

	assign x_out = res.x;
	assign y_out = res.y;
	assign z_out = res.z;

endmodule
`default_nettype wire
